>>> hw/rtl/pbts_pkg.sv
// Package for the priority bitmap task scheduler.
// Holds the shared types: task modes, function codes, cell commands and the chain record.
// No dependencies.
package pbts_pkg;

    localparam int ID_W   = 8;
    localparam int CNT_W  = 9;
    localparam int PRIO_W = 5;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [PRIO_W-1:0] prio_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_READY    = 3'd1,
        MODE_RUNNING  = 3'd2,
        MODE_SLEEPING = 3'd3,
        MODE_BLOCKED  = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        FN_ADD     = 4'd0,
        FN_REMOVE  = 4'd1,
        FN_PICK    = 4'd2,
        FN_SLEEP   = 4'd3,
        FN_WAKE    = 4'd4,
        FN_BLOCK   = 4'd5,
        FN_UNBLOCK = 4'd6,
        FN_TICK    = 4'd7,
        FN_SETCUR  = 4'd8
    } func_t;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ENQ    = 3'd1,
        OP_DEQ    = 3'd2,
        OP_SLEEP  = 3'd3,
        OP_RUN    = 3'd4,
        OP_CHARGE = 3'd5
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_PASS1 = 3'd1,
        S_DEC1  = 3'd2,
        S_PASS2 = 3'd3,
        S_DEC2  = 3'd4,
        S_PASS3 = 3'd5,
        S_DEC3  = 3'd6,
        S_DONE  = 3'd7
    } fsm_t;

    // Broadcast to every cell: one update and the query of the running sweep.
    typedef struct packed {
        cell_op_t    op;
        id_t         id;
        prio_t       prio;
        logic [63:0] dl;
        logic [63:0] wake;
        cnt_t        k;
        cnt_t        q;
        mode_t       new_mode;
        logic        unsleep;
        logic        rot;
        cnt_t        qlen;
        logic [7:0]  quantum;
        id_t         qt;
        prio_t       qp;
        logic [63:0] qd;
        logic [63:0] qw;
    } cell_cmd_t;

    // Record handed from cell to cell during a sweep.
    typedef struct packed {
        mode_t       tgt_mode;
        prio_t       tgt_prio;
        cnt_t        tgt_qpos;
        cnt_t        tgt_spos;
        logic [7:0]  tgt_slice;
        logic [63:0] tgt_dl;
        logic        top_found;
        prio_t       top_prio;
        id_t         top_id;
        logic        sh_found;
        id_t         sh_id;
        prio_t       sh_prio;
        logic [63:0] sh_dl;
        logic [63:0] sh_wake;
        cnt_t        qlen;
        logic        ins_found;
        cnt_t        ins_pos;
        cnt_t        scnt;
    } chain_t;

endpackage

>>> hw/rtl/pbts_cell.sv
// One task slot of the scheduler chain: mode, priority, deadline, wake tick,
// slice and list positions. Folds its slot into the sweep record. Uses pbts_pkg.
module pbts_cell
    import pbts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  id_t       cell_id,
    input  cell_cmd_t cmd,
    input  chain_t    chain_in,
    output chain_t    chain_out
);

    mode_t       mode_reg, mode_next;
    prio_t       prio_reg, prio_next;
    logic [63:0] dl_reg, dl_next;
    logic [63:0] wake_reg, wake_next;
    logic [7:0]  slice_reg, slice_next;
    cnt_t        qpos_reg, qpos_next;
    cnt_t        spos_reg, spos_next;
    chain_t      chain_reg, chain_next;

    logic        me;
    logic        queued;
    logic        same_q;
    logic        sleeping;
    logic [7:0]  slice_dec;

    assign me        = (cell_id == cmd.id);
    assign queued    = (mode_reg == MODE_READY) || (mode_reg == MODE_RUNNING);
    assign same_q    = queued && (prio_reg == cmd.prio);
    assign sleeping  = (mode_reg == MODE_SLEEPING);
    assign slice_dec = (slice_reg == 8'd0) ? 8'd0 : slice_reg - 8'd1;
    assign chain_out = chain_reg;

    // Fold this slot into the sweep record.
    always_comb
    begin
        chain_next = chain_in;
        if (cell_id == cmd.qt)
        begin
            chain_next.tgt_mode  = mode_reg;
            chain_next.tgt_prio  = prio_reg;
            chain_next.tgt_qpos  = qpos_reg;
            chain_next.tgt_spos  = spos_reg;
            chain_next.tgt_slice = slice_reg;
            chain_next.tgt_dl    = dl_reg;
        end
        if (queued && (qpos_reg == '0) &&
            (!chain_in.top_found || (prio_reg > chain_in.top_prio)))
        begin
            chain_next.top_found = 1'b1;
            chain_next.top_prio  = prio_reg;
            chain_next.top_id    = cell_id;
        end
        if (sleeping && (spos_reg == '0))
        begin
            chain_next.sh_found = 1'b1;
            chain_next.sh_id    = cell_id;
            chain_next.sh_prio  = prio_reg;
            chain_next.sh_dl    = dl_reg;
            chain_next.sh_wake  = wake_reg;
        end
        if (queued && (prio_reg == cmd.qp))
        begin
            chain_next.qlen = chain_in.qlen + cnt_t'(1);
            if (((dl_reg == 64'd0) || (dl_reg > cmd.qd)) &&
                (!chain_in.ins_found || (qpos_reg < chain_in.ins_pos)))
            begin
                chain_next.ins_found = 1'b1;
                chain_next.ins_pos   = qpos_reg;
            end
        end
        if (sleeping && (wake_reg <= cmd.qw))
        begin
            chain_next.scnt = chain_in.scnt + cnt_t'(1);
        end
    end

    // Apply the broadcast update.
    always_comb
    begin
        mode_next  = mode_reg;
        prio_next  = prio_reg;
        dl_next    = dl_reg;
        wake_next  = wake_reg;
        slice_next = slice_reg;
        qpos_next  = qpos_reg;
        spos_next  = spos_reg;
        case (cmd.op)
            OP_ENQ:
            begin
                if (me)
                begin
                    mode_next = MODE_READY;
                    prio_next = cmd.prio;
                    dl_next   = cmd.dl;
                    qpos_next = cmd.k;
                    if (slice_reg == 8'd0)
                    begin
                        slice_next = cmd.quantum;
                    end
                end
                else
                begin
                    if (same_q && (qpos_reg >= cmd.k))
                    begin
                        qpos_next = qpos_reg + cnt_t'(1);
                    end
                    if (cmd.unsleep && sleeping && (spos_reg > cmd.q))
                    begin
                        spos_next = spos_reg - cnt_t'(1);
                    end
                end
            end
            OP_DEQ:
            begin
                if (me)
                begin
                    mode_next = cmd.new_mode;
                end
                else if (same_q && (qpos_reg > cmd.q))
                begin
                    qpos_next = qpos_reg - cnt_t'(1);
                end
            end
            OP_SLEEP:
            begin
                if (me)
                begin
                    mode_next = MODE_SLEEPING;
                    wake_next = cmd.wake;
                    spos_next = cmd.k;
                end
                else
                begin
                    if (same_q && (qpos_reg > cmd.q))
                    begin
                        qpos_next = qpos_reg - cnt_t'(1);
                    end
                    if (sleeping && (spos_reg >= cmd.k))
                    begin
                        spos_next = spos_reg + cnt_t'(1);
                    end
                end
            end
            OP_RUN:
            begin
                if (me)
                begin
                    mode_next = MODE_RUNNING;
                end
            end
            OP_CHARGE:
            begin
                if (me)
                begin
                    slice_next = (slice_dec == 8'd0) ? cmd.quantum : slice_dec;
                    if (cmd.rot)
                    begin
                        qpos_next = cmd.qlen - cnt_t'(1);
                    end
                end
                else if (cmd.rot && same_q && (qpos_reg != '0))
                begin
                    qpos_next = qpos_reg - cnt_t'(1);
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            slice_reg <= 8'd0;
            chain_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            slice_reg <= slice_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        dl_reg   <= dl_next;
        wake_reg <= wake_next;
        qpos_reg <= qpos_next;
        spos_reg <= spos_next;
    end

endmodule

>>> hw/rtl/priority_bitmap_task_scheduler.sv
// Top level of the priority bitmap task scheduler: command sequencer and the row of task cells.
// Depends on pbts_pkg and pbts_cell.
//
//  channel   signals                                         direction  handshake
//  command   start, busy, func, task_id, priority_req,      in         start && !busy
//            deadline, sleep_ticks
//  result    done, next_valid, next_task, ready_count,       out        done, one cycle
//            context_switches, status
//  config    cfg_valid, cfg_ready, cfg_data                   in         cfg_valid && cfg_ready
//
// Every task slot lives in one cell. Ready queues and the sleep list are kept as positions
// inside each cell; a sweep carries a record down the row, one cell per cycle, and an update
// is applied to all cells at once. Set current and out-of-range requests need no sweep; pick,
// remove, sleep and block take one sweep; add, wake and unblock take two. A tick takes
// two sweeps per woken task and one more, plus a charge sweep when the running task is
// charged.
// Reset clears modes, slices, counters and the current task at once; no clearing pass.
// busy stays high from acceptance until the done cycle; the receiver cannot stall.
module priority_bitmap_task_scheduler
    import pbts_pkg::*;
#(
    parameter int NUM_TASKS      = 32,
    parameter int NUM_PRIORITIES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  func,
    input  logic [4:0]  task_id,
    input  logic [7:0]  priority_req,
    input  logic [63:0] deadline,
    input  logic [31:0] sleep_ticks,
    output logic        done,
    output logic        next_valid,
    output logic [4:0]  next_task,
    output logic [5:0]  ready_count,
    output logic [63:0] context_switches,
    output logic        status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int PC_W = $clog2(NUM_TASKS + 1);

    fsm_t            state_reg, state_next;
    logic [PC_W-1:0] pass_cnt_reg, pass_cnt_next;
    logic            pass_done;

    func_t       func_reg, func_next;
    id_t         tid_reg, tid_next;
    id_t         qt_reg, qt_next;
    prio_t       qp_reg, qp_next;
    logic [63:0] qd_reg, qd_next;
    logic [63:0] qw_reg, qw_next;
    id_t         en_id_reg, en_id_next;
    logic        en_unsleep_reg, en_unsleep_next;
    cnt_t        en_sq_reg, en_sq_next;
    chain_t      res_reg, res_next;

    logic [7:0]  quantum_reg;
    id_t         cur_reg, cur_next;
    logic        cur_vld_reg, cur_vld_next;
    logic [63:0] tick_reg, tick_next;
    cnt_t        ready_total_reg, ready_total_next;
    logic [63:0] switch_reg, switch_next;
    logic        nv_reg, nv_next;
    logic [4:0]  nt_reg, nt_next;
    logic        st_reg, st_next;

    cell_cmd_t   cmd;
    chain_t      links [NUM_TASKS+1];

    logic        ok_id;
    logic        needs_id;
    logic        tgt_queued;
    prio_t       prio_clamped;
    logic [63:0] wake_at;

    assign ok_id        = (32'(task_id) < NUM_TASKS);
    assign needs_id     = (func <= 4'(FN_SETCUR)) && (func != 4'(FN_PICK)) &&
                          (func != 4'(FN_TICK));
    assign prio_clamped = (32'(priority_req) > NUM_PRIORITIES - 1) ?
                          prio_t'(NUM_PRIORITIES - 1) : prio_t'(priority_req);
    assign wake_at      = tick_reg + 64'((sleep_ticks == 32'd0) ? 32'd1 : sleep_ticks);
    assign tgt_queued   = (res_reg.tgt_mode == MODE_READY) ||
                          (res_reg.tgt_mode == MODE_RUNNING);
    assign pass_done    = (pass_cnt_reg == PC_W'(NUM_TASKS));

    assign busy             = (state_reg != S_IDLE);
    assign done             = (state_reg == S_DONE);
    assign next_valid       = nv_reg;
    assign next_task        = nt_reg;
    assign status           = st_reg;
    assign ready_count      = 6'(ready_total_reg);
    assign context_switches = switch_reg;
    assign cfg_ready        = 1'b1;

    // Row of cells; the sweep record enters at the first cell as all zeros.
    assign links[0] = '0;
    for (genvar i = 0; i < NUM_TASKS; i++)
    begin : g_cell
        pbts_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (id_t'(i)),
            .cmd       (cmd),
            .chain_in  (links[i]),
            .chain_out (links[i+1])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if ((func == 4'(FN_PICK)) || (func == 4'(FN_TICK)))
                    begin
                        state_next = S_PASS1;
                    end
                    else if (needs_id && ok_id && (func != 4'(FN_SETCUR)))
                    begin
                        state_next = S_PASS1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PASS1:
            begin
                if (pass_done)
                begin
                    state_next = S_DEC1;
                end
            end
            S_DEC1:
            begin
                state_next = S_DONE;
                case (func_reg)
                    FN_ADD:
                    begin
                        if (res_reg.tgt_mode == MODE_IDLE)
                        begin
                            state_next = S_PASS2;
                        end
                    end
                    FN_WAKE:
                    begin
                        if (res_reg.tgt_mode == MODE_SLEEPING)
                        begin
                            state_next = S_PASS2;
                        end
                    end
                    FN_UNBLOCK:
                    begin
                        if (res_reg.tgt_mode == MODE_BLOCKED)
                        begin
                            state_next = S_PASS2;
                        end
                    end
                    FN_TICK:
                    begin
                        if (res_reg.sh_found && (res_reg.sh_wake <= tick_reg))
                        begin
                            state_next = S_PASS2;
                        end
                        else if (cur_vld_reg && (res_reg.tgt_mode == MODE_RUNNING))
                        begin
                            state_next = S_PASS3;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_PASS2:
            begin
                if (pass_done)
                begin
                    state_next = S_DEC2;
                end
            end
            S_DEC2:
            begin
                state_next = (func_reg == FN_TICK) ? S_PASS1 : S_DONE;
            end
            S_PASS3:
            begin
                if (pass_done)
                begin
                    state_next = S_DEC3;
                end
            end
            S_DEC3:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and cell commands.
    always_comb
    begin
        func_next        = func_reg;
        tid_next         = tid_reg;
        qt_next          = qt_reg;
        qp_next          = qp_reg;
        qd_next          = qd_reg;
        qw_next          = qw_reg;
        en_id_next       = en_id_reg;
        en_unsleep_next  = en_unsleep_reg;
        en_sq_next       = en_sq_reg;
        res_next         = res_reg;
        cur_next         = cur_reg;
        cur_vld_next     = cur_vld_reg;
        tick_next        = tick_reg;
        ready_total_next = ready_total_reg;
        switch_next      = switch_reg;
        nv_next          = nv_reg;
        nt_next          = nt_reg;
        st_next          = st_reg;
        pass_cnt_next    = '0;

        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.new_mode = MODE_IDLE;
        cmd.quantum  = quantum_reg;
        cmd.qt       = qt_reg;
        cmd.qp       = qp_reg;
        cmd.qd       = qd_reg;
        cmd.qw       = qw_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next = func_t'(func);
                    tid_next  = id_t'(task_id);
                    qp_next   = prio_clamped;
                    qd_next   = deadline;
                    qw_next   = wake_at;
                    qt_next   = (func == 4'(FN_TICK)) ? cur_reg : id_t'(task_id);
                    nv_next   = 1'b0;
                    nt_next   = 5'd0;
                    st_next   = needs_id && !ok_id;
                    if (func == 4'(FN_TICK))
                    begin
                        tick_next = tick_reg + 64'd1;
                    end
                    if ((func == 4'(FN_SETCUR)) && ok_id)
                    begin
                        cur_next     = id_t'(task_id);
                        cur_vld_next = 1'b1;
                    end
                end
            end
            S_PASS1, S_PASS2, S_PASS3:
            begin
                // Advance the sweep; capture the record once it leaves the last cell.
                pass_cnt_next = pass_cnt_reg + PC_W'(1);
                if (pass_done)
                begin
                    pass_cnt_next = '0;
                    res_next      = links[NUM_TASKS];
                end
            end
            S_DEC1:
            begin
                case (func_reg)
                    FN_PICK:
                    begin
                        if (res_reg.top_found)
                        begin
                            cmd.op       = OP_RUN;
                            cmd.id       = res_reg.top_id;
                            nv_next      = 1'b1;
                            nt_next      = 5'(res_reg.top_id);
                            cur_next     = res_reg.top_id;
                            cur_vld_next = 1'b1;
                            if (!cur_vld_reg || (cur_reg != res_reg.top_id))
                            begin
                                switch_next = switch_reg + 64'd1;
                            end
                        end
                    end
                    FN_ADD:
                    begin
                        if (res_reg.tgt_mode != MODE_IDLE)
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            en_id_next      = tid_reg;
                            en_unsleep_next = 1'b0;
                        end
                    end
                    FN_REMOVE, FN_BLOCK:
                    begin
                        if (!tgt_queued)
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            cmd.op       = OP_DEQ;
                            cmd.id       = tid_reg;
                            cmd.prio     = res_reg.tgt_prio;
                            cmd.q        = res_reg.tgt_qpos;
                            cmd.new_mode = (func_reg == FN_BLOCK) ? MODE_BLOCKED : MODE_IDLE;
                            if (ready_total_reg != '0)
                            begin
                                ready_total_next = ready_total_reg - cnt_t'(1);
                            end
                        end
                    end
                    FN_SLEEP:
                    begin
                        if (!tgt_queued)
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            // Leave the ready queue and take a place in the sleep list.
                            cmd.op   = OP_SLEEP;
                            cmd.id   = tid_reg;
                            cmd.prio = res_reg.tgt_prio;
                            cmd.q    = res_reg.tgt_qpos;
                            cmd.wake = qw_reg;
                            cmd.k    = res_reg.scnt;
                            if (ready_total_reg != '0)
                            begin
                                ready_total_next = ready_total_reg - cnt_t'(1);
                            end
                        end
                    end
                    FN_WAKE:
                    begin
                        if (res_reg.tgt_mode != MODE_SLEEPING)
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            en_id_next      = tid_reg;
                            en_unsleep_next = 1'b1;
                            en_sq_next      = res_reg.tgt_spos;
                            qp_next         = res_reg.tgt_prio;
                            qd_next         = res_reg.tgt_dl;
                        end
                    end
                    FN_UNBLOCK:
                    begin
                        if (res_reg.tgt_mode != MODE_BLOCKED)
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            en_id_next      = tid_reg;
                            en_unsleep_next = 1'b0;
                            qp_next         = res_reg.tgt_prio;
                            qd_next         = res_reg.tgt_dl;
                        end
                    end
                    FN_TICK:
                    begin
                        if (res_reg.sh_found && (res_reg.sh_wake <= tick_reg))
                        begin
                            en_id_next      = res_reg.sh_id;
                            en_unsleep_next = 1'b1;
                            en_sq_next      = '0;
                            qp_next         = res_reg.sh_prio;
                            qd_next         = res_reg.sh_dl;
                        end
                        else
                        begin
                            qp_next = res_reg.tgt_prio;
                        end
                    end
                    default:
                    begin
                        st_next = st_reg;
                    end
                endcase
            end
            S_DEC2:
            begin
                // Append at the tail, or in deadline order when a deadline is set.
                cmd.op      = OP_ENQ;
                cmd.id      = en_id_reg;
                cmd.prio    = qp_reg;
                cmd.dl      = qd_reg;
                cmd.k       = ((qd_reg != 64'd0) && res_reg.ins_found) ?
                              res_reg.ins_pos : res_reg.qlen;
                cmd.unsleep = en_unsleep_reg;
                cmd.q       = en_sq_reg;
                ready_total_next = ready_total_reg + cnt_t'(1);
                switch_next      = switch_reg + 64'd1;
            end
            S_DEC3:
            begin
                // Charge the running task; rotate the head to the tail on slice expiry.
                cmd.op   = OP_CHARGE;
                cmd.id   = cur_reg;
                cmd.prio = res_reg.tgt_prio;
                cmd.qlen = res_reg.qlen;
                cmd.rot  = (res_reg.tgt_slice <= 8'd1) && (res_reg.tgt_qpos == '0) &&
                           (res_reg.qlen >= cnt_t'(2));
            end
            default:
            begin
                pass_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pass_cnt_reg    <= '0;
            quantum_reg     <= 8'd10;
            cur_reg         <= '0;
            cur_vld_reg     <= 1'b0;
            tick_reg        <= 64'd0;
            ready_total_reg <= '0;
            switch_reg      <= 64'd0;
            nv_reg          <= 1'b0;
            nt_reg          <= 5'd0;
            st_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pass_cnt_reg    <= pass_cnt_next;
            cur_reg         <= cur_next;
            cur_vld_reg     <= cur_vld_next;
            tick_reg        <= tick_next;
            ready_total_reg <= ready_total_next;
            switch_reg      <= switch_next;
            nv_reg          <= nv_next;
            nt_reg          <= nt_next;
            st_reg          <= st_next;
            if (cfg_valid && cfg_ready)
            begin
                quantum_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        tid_reg        <= tid_next;
        qt_reg         <= qt_next;
        qp_reg         <= qp_next;
        qd_reg         <= qd_next;
        qw_reg         <= qw_next;
        en_id_reg      <= en_id_next;
        en_unsleep_reg <= en_unsleep_next;
        en_sq_reg      <= en_sq_next;
        res_reg        <= res_next;
    end

    // An accepted transaction holds the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // No result sets next_valid and status together.
    a_pick_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(next_valid && status))
        else $error("next_valid and status both set");

    // The ready count cannot exceed the number of task slots.
    a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(ready_total_reg) <= NUM_TASKS))
        else $error("ready count above task count");

    // Cells change state only after an accepted transaction.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cmd.op == OP_NONE))
        else $error("cell update while idle");

endmodule

>>> bench/pbts_checker.sv
// Checker for the priority bitmap task scheduler: watches the command, result and config channels.
// Predicts every result from its own scheduler state and compares field by field.
// Depends on pbts_pkg.
module pbts_checker
    import pbts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [3:0]  func,
    input  logic [4:0]  task_id,
    input  logic [7:0]  priority_req,
    input  logic [63:0] deadline,
    input  logic [31:0] sleep_ticks,
    input  logic        done,
    input  logic        next_valid,
    input  logic [4:0]  next_task,
    input  logic [5:0]  ready_count,
    input  logic [63:0] context_switches,
    input  logic        status,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          accepted,
    output int          cfg_writes,
    output int          awaiting,
    output int          results_seen
);

    localparam bit [5:0] NONE = 6'd32;

    typedef struct packed {
        logic        nv;
        logic [4:0]  nt;
        logic [5:0]  rc;
        logic [63:0] cs;
        logic        st;
    } sched_result_t;

    sched_result_t result_fifo[$];

    bit [7:0]  quantum;
    bit [31:0] bitmap;
    bit [5:0]  qhead[32];
    bit [5:0]  qtail[32];
    bit [5:0]  lnext[32];
    bit [5:0]  lprev[32];
    bit [4:0]  tprio[32];
    bit [63:0] tdl[32];
    bit [63:0] wake_at[32];
    bit [7:0]  slice[32];
    bit [31:0] run_cnt[32];
    mode_t     tmode[32];
    bit [5:0]  sleep_head;
    bit [5:0]  running_id;
    bit [63:0] now_tick;
    bit [5:0]  ready_num;
    bit [63:0] switch_num;

    function automatic void sched_clear();
        quantum = 8'd10;
        bitmap  = '0;
        for (int i = 0; i < 32; i++) begin
            qhead[i] = '0; qtail[i] = '0;
            lnext[i] = NONE; lprev[i] = NONE;
            tprio[i] = '0; tdl[i] = '0; wake_at[i] = '0;
            slice[i] = '0; run_cnt[i] = '0;
            tmode[i] = MODE_IDLE;
        end
        sleep_head = NONE;
        running_id = NONE;
        now_tick   = '0;
        ready_num  = '0;
        switch_num = '0;
    endfunction

    // Append to the tail, or slot in by deadline when a deadline is set and the queue is nonempty.
    function automatic void ready_insert(bit [4:0] t);
        bit [4:0]  p;
        bit [63:0] d;
        bit [5:0]  c;
        bit [5:0]  pv;
        p = tprio[t];
        d = tdl[t];
        if (slice[t] == 0) slice[t] = quantum;
        if (d != 0 && bitmap[p]) begin
            c  = qhead[p];
            pv = NONE;
            while (c != NONE && tdl[c[4:0]] != 0 && tdl[c[4:0]] <= d) begin
                pv = c;
                c  = lnext[c[4:0]];
            end
            lprev[t] = pv;
            lnext[t] = c;
            if (pv == NONE) qhead[p] = t; else lnext[pv[4:0]] = t;
            if (c == NONE) qtail[p] = t; else lprev[c[4:0]] = t;
        end else begin
            lnext[t] = NONE;
            if (bitmap[p]) begin
                lprev[t] = qtail[p];
                lnext[qtail[p][4:0]] = t;
            end else begin
                lprev[t] = NONE;
                qhead[p] = t;
            end
            qtail[p] = t;
        end
        bitmap[p]  = 1'b1;
        ready_num  = ready_num + 1;
        tmode[t]   = MODE_READY;
        switch_num = switch_num + 1;
    endfunction

    function automatic void ready_unlink(bit [4:0] t);
        bit [4:0] p;
        bit [5:0] pv;
        bit [5:0] nx;
        p  = tprio[t];
        pv = lprev[t];
        nx = lnext[t];
        if (pv != NONE) lnext[pv[4:0]] = nx; else qhead[p] = nx;
        if (nx != NONE) lprev[nx[4:0]] = pv; else qtail[p] = pv;
        lprev[t] = NONE;
        lnext[t] = NONE;
        if (qhead[p] == NONE) bitmap[p] = 1'b0;
        if (ready_num != 0) ready_num = ready_num - 1;
        tmode[t] = MODE_IDLE;
    endfunction

    function automatic void sleeper_insert(bit [4:0] t);
        bit [63:0] w;
        bit [5:0]  c;
        w = wake_at[t];
        if (sleep_head == NONE || w < wake_at[sleep_head[4:0]]) begin
            lnext[t] = sleep_head;
            lprev[t] = NONE;
            if (sleep_head != NONE) lprev[sleep_head[4:0]] = t;
            sleep_head = t;
        end else begin
            c = sleep_head;
            while (lnext[c[4:0]] != NONE && wake_at[lnext[c[4:0]][4:0]] <= w)
                c = lnext[c[4:0]];
            lnext[t] = lnext[c[4:0]];
            lprev[t] = c;
            if (lnext[c[4:0]] != NONE) lprev[lnext[c[4:0]][4:0]] = t;
            lnext[c[4:0]] = t;
        end
        tmode[t] = MODE_SLEEPING;
    endfunction

    function automatic void sleeper_unlink(bit [4:0] t);
        bit [5:0] pv;
        bit [5:0] nx;
        pv = lprev[t];
        nx = lnext[t];
        if (pv != NONE) lnext[pv[4:0]] = nx; else sleep_head = nx;
        if (nx != NONE) lprev[nx[4:0]] = pv;
        lprev[t] = NONE;
        lnext[t] = NONE;
        tmode[t] = MODE_IDLE;
    endfunction

    // Advance time, wake expired sleepers, charge the running task and rotate it on expiry.
    function automatic void tick_advance();
        bit [5:0] c;
        bit [4:0] w;
        bit [4:0] p;
        bit [5:0] nh;
        c = running_id;
        now_tick = now_tick + 1;
        while (sleep_head != NONE && wake_at[sleep_head[4:0]] <= now_tick) begin
            w = sleep_head[4:0];
            sleeper_unlink(w);
            ready_insert(w);
        end
        if (c == NONE || tmode[c[4:0]] != MODE_RUNNING) return;
        run_cnt[c[4:0]] = run_cnt[c[4:0]] + 1;
        if (slice[c[4:0]] > 0) slice[c[4:0]] = slice[c[4:0]] - 1;
        if (slice[c[4:0]] == 0) begin
            p = tprio[c[4:0]];
            slice[c[4:0]] = quantum;
            if (bitmap[p] && qhead[p] != qtail[p] && qhead[p] == c) begin
                nh = lnext[c[4:0]];
                qhead[p] = nh;
                lprev[nh[4:0]] = NONE;
                lnext[qtail[p][4:0]] = c;
                lprev[c[4:0]] = qtail[p];
                lnext[c[4:0]] = NONE;
                qtail[p] = c;
            end
        end
    endfunction

    function automatic sched_result_t sched_step(bit [3:0] f, bit [4:0] t, bit [7:0] pr,
                                                 bit [63:0] dl, bit [31:0] sl);
        sched_result_t r;
        mode_t         m;
        bit            queued;
        bit [4:0]      p;
        r = '0;
        m = tmode[t];
        queued = (m == MODE_READY || m == MODE_RUNNING);
        case (f)
            FN_PICK: begin
                if (bitmap != 0) begin
                    p = 5'd31;
                    while (p > 0 && !bitmap[p]) p = p - 1;
                    if (qhead[p] != running_id) switch_num = switch_num + 1;
                    running_id = qhead[p];
                    tmode[qhead[p][4:0]] = MODE_RUNNING;
                    r.nv = 1'b1;
                    r.nt = qhead[p][4:0];
                end
            end
            FN_TICK: tick_advance();
            FN_ADD: begin
                if (m != MODE_IDLE) r.st = 1'b1;
                else begin
                    tprio[t] = (pr > 8'd31) ? 5'd31 : pr[4:0];
                    tdl[t]   = dl;
                    ready_insert(t);
                end
            end
            FN_REMOVE: begin
                if (!queued) r.st = 1'b1; else ready_unlink(t);
            end
            FN_SLEEP: begin
                if (!queued) r.st = 1'b1;
                else begin
                    ready_unlink(t);
                    wake_at[t] = now_tick + ((sl != 0) ? 64'(sl) : 64'd1);
                    sleeper_insert(t);
                end
            end
            FN_WAKE: begin
                if (m != MODE_SLEEPING) r.st = 1'b1;
                else begin
                    sleeper_unlink(t);
                    ready_insert(t);
                end
            end
            FN_BLOCK: begin
                if (!queued) r.st = 1'b1;
                else begin
                    ready_unlink(t);
                    tmode[t] = MODE_BLOCKED;
                end
            end
            FN_UNBLOCK: begin
                if (m != MODE_BLOCKED) r.st = 1'b1; else ready_insert(t);
            end
            FN_SETCUR: running_id = t;
            default: ;
        endcase
        r.rc = ready_num;
        r.cs = switch_num;
        return r;
    endfunction

    assign awaiting = result_fifo.size();

    always @(posedge clk or negedge rst_n) begin
        sched_result_t exp_r;
        if (!rst_n) begin
            sched_clear();
            result_fifo.delete();
            mismatches   <= 0;
            accepted     <= 0;
            cfg_writes   <= 0;
            results_seen <= 0;
        end else begin
            // Retire the finished transaction before taking a new one.
            if (done) begin
                results_seen <= results_seen + 1;
                if (result_fifo.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing outstanding", $time);
                    mismatches <= mismatches + 1;
                end else begin
                    exp_r = result_fifo.pop_front();
                    if (exp_r.nv !== next_valid || exp_r.nt !== next_task ||
                        exp_r.rc !== ready_count || exp_r.cs !== context_switches ||
                        exp_r.st !== status) begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch exp nv=%0d nt=%0d rc=%0d cs=%0d st=%0d",
                                      " got nv=%0d nt=%0d rc=%0d cs=%0d st=%0d"}, $time,
                                     exp_r.nv, exp_r.nt, exp_r.rc, exp_r.cs, exp_r.st,
                                     next_valid, next_task, ready_count, context_switches,
                                     status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (start && !busy) begin
                result_fifo.push_back(sched_step(func, task_id, priority_req, deadline,
                                                 sleep_ticks));
                accepted <= accepted + 1;
            end
            if (cfg_valid && cfg_ready) begin
                quantum    = cfg_data;
                cfg_writes <= cfg_writes + 1;
            end
        end
    end

endmodule

>>> bench/tb_priority_bitmap_task_scheduler.sv
// Testbench top for the priority bitmap task scheduler: clock, reset, stimulus and verdict.
// Depends on pbts_pkg, pbts_checker and the scheduler RTL.
module tb_priority_bitmap_task_scheduler;
    import pbts_pkg::*;

    // Worst ticks can wake up to 32 sleepers; stay well clear of that.
    localparam int CYCLE_LIMIT = 6000000;
    localparam int PHASE_ITEMS = 300;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  func;
    logic [4:0]  task_id;
    logic [7:0]  priority_req;
    logic [63:0] deadline;
    logic [31:0] sleep_ticks;
    logic        done;
    logic        next_valid;
    logic [4:0]  next_task;
    logic [5:0]  ready_count;
    logic [63:0] context_switches;
    logic        status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int mismatches;
    int accepted;
    int cfg_writes;
    int awaiting;
    int results_seen;
    int cycles;
    int pool;
    bit no_gaps;

    priority_bitmap_task_scheduler i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .task_id          (task_id),
        .priority_req     (priority_req),
        .deadline         (deadline),
        .sleep_ticks      (sleep_ticks),
        .done             (done),
        .next_valid       (next_valid),
        .next_task        (next_task),
        .ready_count      (ready_count),
        .context_switches (context_switches),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    pbts_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .task_id          (task_id),
        .priority_req     (priority_req),
        .deadline         (deadline),
        .sleep_ticks      (sleep_ticks),
        .done             (done),
        .next_valid       (next_valid),
        .next_task        (next_task),
        .ready_count      (ready_count),
        .context_switches (context_switches),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .accepted         (accepted),
        .cfg_writes       (cfg_writes),
        .awaiting         (awaiting),
        .results_seen     (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake must still end the run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_priority_bitmap_task_scheduler: errors");
            $finish;
        end
    end

    // Issue one command transaction: hold start until the checker sees it accepted,
    // then drop start. The trailing negedge keeps the next raise in a later time step.
    task automatic issue(input logic [3:0] f, input logic [4:0] t, input logic [7:0] pr,
                         input logic [63:0] dl, input logic [31:0] sl);
        int gap;
        int seen;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        repeat (gap) @(negedge clk);
        seen = accepted;
        start        <= 1'b1;
        func         <= f;
        task_id      <= t;
        priority_req <= pr;
        deadline     <= dl;
        sleep_ticks  <= sl;
        do @(negedge clk); while (accepted == seen);
        start <= 1'b0;
        @(negedge clk);
    endtask

    // Write the quantum only with nothing in flight, then hold until the write lands.
    task automatic set_quantum(input logic [7:0] q);
        int seen;
        while (awaiting != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_data  <= q;
        do @(negedge clk); while (cfg_writes == seen);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [3:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18) return FN_ADD;
        if (r < 24) return FN_REMOVE;
        if (r < 41) return FN_PICK;
        if (r < 50) return FN_SLEEP;
        if (r < 56) return FN_WAKE;
        if (r < 62) return FN_BLOCK;
        if (r < 70) return FN_UNBLOCK;
        if (r < 95) return FN_TICK;
        if (r < 99) return FN_SETCUR;
        return 4'($urandom_range(9, 15));
    endfunction

    // Bias priorities toward a few crowded levels at both ends of the range.
    function automatic logic [7:0] pick_prio();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'($urandom_range(0, 3));
        if (r < 7) return 8'($urandom_range(29, 40));
        return 8'($urandom);
    endfunction

    // Mix of no deadline, close small deadlines and the full 64-bit span.
    function automatic logic [63:0] pick_deadline();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)  return '0;
        if (r < 17) return 64'($urandom_range(1, 20));
        if (r < 19) return {$urandom, $urandom};
        return '1;
    endfunction

    // Mostly short sleeps so tasks come back; a few long ones park for good.
    function automatic logic [31:0] pick_sleep();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 32'($urandom_range(0, 4));
        if (r < 9) return 32'($urandom_range(5, 40));
        return $urandom;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            issue(pick_func(), 5'($urandom_range(0, pool - 1)), pick_prio(),
                  pick_deadline(), pick_sleep());
        end
    endtask

    initial
    begin
        cycles       = 0;
        no_gaps      = 1'b0;
        pool         = 8;
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = FN_TICK;
        task_id      = '0;
        priority_req = '0;
        deadline     = '0;
        sleep_ticks  = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty pick, extremes, sorted insert, wrong-state requests, unused codes.
        issue(FN_PICK,    5'd0,  8'd0,   64'd0, 32'd0);
        issue(FN_ADD,     5'd0,  8'd0,   64'd0, 32'd0);
        issue(FN_ADD,     5'd31, 8'd255, '1,    32'd0);
        issue(FN_ADD,     5'd5,  8'd31,  64'd5, 32'd0);
        issue(FN_ADD,     5'd6,  8'd31,  64'd3, 32'd0);
        issue(FN_ADD,     5'd7,  8'd31,  64'd0, 32'd0);
        issue(FN_ADD,     5'd0,  8'd4,   64'd0, 32'd0);
        issue(FN_PICK,    5'd0,  8'd0,   64'd0, 32'd0);
        issue(FN_TICK,    5'd0,  8'd0,   64'd0, 32'd0);
        issue(FN_SLEEP,   5'd31, 8'd0,   64'd0, 32'd0);
        issue(FN_SLEEP,   5'd5,  8'd0,   64'd0, '1);
        issue(FN_WAKE,    5'd5,  8'd0,   64'd0, 32'd0);
        issue(FN_BLOCK,   5'd6,  8'd0,   64'd0, 32'd0);
        issue(FN_UNBLOCK, 5'd6,  8'd0,   64'd0, 32'd0);
        issue(FN_UNBLOCK, 5'd6,  8'd0,   64'd0, 32'd0);
        issue(FN_REMOVE,  5'd7,  8'd0,   64'd0, 32'd0);
        issue(FN_REMOVE,  5'd7,  8'd0,   64'd0, 32'd0);
        issue(FN_SETCUR,  5'd3,  8'd0,   64'd0, 32'd0);
        issue(FN_TICK,    5'd0,  8'd0,   64'd0, 32'd0);
        issue(FN_TICK,    5'd0,  8'd0,   64'd0, 32'd0);
        issue(FN_WAKE,    5'd9,  8'd0,   64'd0, 32'd0);
        issue(4'd15,      5'd1,  8'd0,   64'd0, 32'd0);
        issue(4'd9,       5'd2,  8'd0,   64'd0, 32'd0);
        issue(FN_PICK,    5'd0,  8'd0,   64'd0, 32'd0);

        // Random phases, each under its own quantum; shortest and longest included.
        random_phase(PHASE_ITEMS);
        set_quantum(8'd1);
        pool = 4;
        random_phase(PHASE_ITEMS);
        set_quantum(8'd255);
        pool = 32;
        random_phase(PHASE_ITEMS);
        set_quantum(8'($urandom_range(2, 254)));
        pool = 8;
        random_phase(PHASE_ITEMS);
        set_quantum(8'd2);
        pool = 16;
        random_phase(PHASE_ITEMS);

        // Drain, then give any stray result time to show up.
        while (awaiting != 0) @(negedge clk);
        repeat (200) @(negedge clk);

        $display("Covered %0d commands over %0d quantum settings, %0d results checked.",
                 accepted, cfg_writes + 1, results_seen);
        if (mismatches == 0 && awaiting == 0)
            $display("tb_priority_bitmap_task_scheduler: clean");
        else
            $display("tb_priority_bitmap_task_scheduler: errors");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/pbts_pkg.sv
hw/rtl/pbts_cell.sv
hw/rtl/priority_bitmap_task_scheduler.sv
bench/pbts_checker.sv
bench/tb_priority_bitmap_task_scheduler.sv
